// ===== hdl/epoch_seconds_to_calendar_macros.svh =====
// assertion macros of the epoch-to-calendar converter, used by its controller
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define ESC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("esc assertion failed");
// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("esc assertion failed");
`else
`define ESC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/esc_pkg.sv =====
// types, constants and the month length table of the epoch-to-calendar converter
package esc_pkg;

	// field widths
	localparam int unsigned EPOCH_W   = 31;
	localparam int unsigned DAYS_W    = 15;
	localparam int unsigned YEAR_W    = 11;

	// reciprocal division: quotient = (scaled dividend * reciprocal) >> shift
	localparam int unsigned MUL_W     = 29;
	localparam int unsigned RECIP_W   = 30;
	localparam int unsigned PROD_W    = MUL_W + RECIP_W;

	// divide by 60 as shift by 2 then 1/15, by 24 as shift by 3 then 1/3, then 1/7
	localparam logic [RECIP_W-1:0] RECIP_15    = 30'd572662307;
	localparam int unsigned        RECIP_15_SH = 33;
	localparam logic [RECIP_W-1:0] RECIP_3     = 30'd715827883;
	localparam int unsigned        RECIP_3_SH  = 31;
	localparam logic [RECIP_W-1:0] RECIP_7     = 30'd613566757;
	localparam int unsigned        RECIP_7_SH  = 32;

	// calendar start: january 1970, 19 centuries is 3 mod 4
	localparam logic [YEAR_W-1:0] EPOCH_YEAR      = 11'd1970;
	localparam logic [6:0]        EPOCH_YEAR_C    = 7'd70;
	localparam logic [1:0]        EPOCH_CENTURY_4 = 2'd3;
	localparam logic [6:0]        LAST_YEAR_C     = 7'd99;
	localparam logic [3:0]        MONTH_JAN       = 4'd0;
	localparam logic [3:0]        MONTH_FEB       = 4'd1;
	localparam logic [3:0]        MONTH_DEC       = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_HOUR,
		PH_DAY
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic   load;
		logic   mul;
		logic   fix;
		phase_t phase;
		logic   walk_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
	} status_t;

	// days in month, january is zero
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
			MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== hdl/epoch_seconds_to_calendar.sv =====
// top level of the epoch-seconds to calendar converter
//
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------------
//  input   | start, busy           | epoch_seconds
//  result  | done (one-cycle pulse)| second minute hour weekday year month
//          |                       | day_of_month
//
// one conversion runs four reciprocal division phases, each a multiply state
// then a fix state, then the month walk, which steps once per month walked
// plus once to end the walk, then the done state; busy drops the cycle after
// done, and the month walk sets how long a conversion takes.
// arst_n clears the controller to idle; the result ports are valid only while
// done is high. results cannot be stalled; start is taken only while busy is low.
module epoch_seconds_to_calendar (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [esc_pkg::EPOCH_W-1:0]  epoch_seconds,
	output logic                         busy,
	output logic                         done,
	output logic [5:0]                   second,
	output logic [5:0]                   minute,
	output logic [4:0]                   hour,
	output logic [2:0]                   weekday,
	output logic [esc_pkg::YEAR_W-1:0]   year,
	output logic [3:0]                   month,
	output logic [4:0]                   day_of_month
);

	esc_pkg::cmd_t    cmd;
	esc_pkg::status_t status;

	// sequencer
	esc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic
	esc_dpath u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.epoch_seconds (epoch_seconds),
		.status        (status),
		.second        (second),
		.minute        (minute),
		.hour          (hour),
		.weekday       (weekday),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month)
	);

endmodule

// ===== hdl/esc_ctrl.sv =====
// controller: sequences the four division phases and the month walk
`include "epoch_seconds_to_calendar_macros.svh"
module esc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  esc_pkg::status_t status,
	output esc_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	esc_pkg::state_t state_q, state_nxt;
	esc_pkg::phase_t phase_q;
	logic            last_phase;

	assign last_phase = (phase_q == esc_pkg::PH_DAY);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			esc_pkg::ST_IDLE: begin
				if (start) state_nxt = esc_pkg::ST_MUL;
			end
			esc_pkg::ST_MUL:  state_nxt = esc_pkg::ST_FIX;
			esc_pkg::ST_FIX: begin
				if (last_phase) state_nxt = esc_pkg::ST_WALK;
				else state_nxt = esc_pkg::ST_MUL;
			end
			esc_pkg::ST_WALK: begin
				if (status.walk_done) state_nxt = esc_pkg::ST_DONE;
			end
			esc_pkg::ST_DONE: state_nxt = esc_pkg::ST_IDLE;
			default:          state_nxt = esc_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd.load      = 1'b0;
		cmd.mul       = 1'b0;
		cmd.fix       = 1'b0;
		cmd.phase     = phase_q;
		cmd.walk_step = 1'b0;
		busy          = 1'b1;
		done          = 1'b0;
		case (state_q)
			esc_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			esc_pkg::ST_MUL:  cmd.mul = 1'b1;
			esc_pkg::ST_FIX:  cmd.fix = 1'b1;
			esc_pkg::ST_WALK: cmd.walk_step = 1'b1;
			esc_pkg::ST_DONE: done = 1'b1;
			default:          busy = 1'b1;
		endcase
	end

	// state and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esc_pkg::ST_IDLE;
			phase_q <= esc_pkg::PH_SEC;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				phase_q <= esc_pkg::PH_SEC;
			end else if (cmd.fix && !last_phase) begin
				phase_q <= esc_pkg::phase_t'(phase_q + 2'd1);
			end
		end
	end

	`ESC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	`ESC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`ESC_ASSERT_NEXT(a_mul_then_fix, clk, arst_n, cmd.mul, cmd.fix)
	`ESC_ASSERT_NEXT(a_day_to_walk, clk, arst_n, cmd.fix && last_phase, state_q == esc_pkg::ST_WALK)
	`ESC_ASSERT_SAME(a_busy_cmds, clk, arst_n, cmd.mul || cmd.fix || cmd.walk_step, busy)

endmodule

// ===== hdl/esc_dpath.sv =====
// datapath: reciprocal divider, month walker and result registers
module esc_dpath (
	input  logic                         clk,
	input  esc_pkg::cmd_t                cmd,
	input  logic [esc_pkg::EPOCH_W-1:0]  epoch_seconds,
	output esc_pkg::status_t             status,
	output logic [5:0]                   second,
	output logic [5:0]                   minute,
	output logic [4:0]                   hour,
	output logic [2:0]                   weekday,
	output logic [esc_pkg::YEAR_W-1:0]   year,
	output logic [3:0]                   month,
	output logic [4:0]                   day_of_month
);

	logic [esc_pkg::EPOCH_W-1:0]   num_q;
	logic [esc_pkg::MUL_W-1:0]     mul_in;
	logic [esc_pkg::RECIP_W-1:0]   recip;
	logic [esc_pkg::PROD_W-1:0]    prod_q, prod_sh;
	logic [esc_pkg::EPOCH_W-1:0]   quo, back, rem;

	logic [esc_pkg::DAYS_W-1:0]    days_q;
	logic [esc_pkg::YEAR_W-1:0]    year_q;
	logic [6:0]                    year_c_q;
	logic [1:0]                    century_q;
	logic [3:0]                    mon_q;
	logic [5:0]                    sec_q, min_q;
	logic [4:0]                    hour_q;
	logic [2:0]                    wd_q;
	logic                          leap, fits;
	logic [4:0]                    len;

	// scaled dividend and reciprocal for the current phase
	always_comb begin
		case (cmd.phase)
			esc_pkg::PH_SEC, esc_pkg::PH_MIN: begin
				mul_in = num_q[esc_pkg::EPOCH_W-1:2];
				recip  = esc_pkg::RECIP_15;
			end
			esc_pkg::PH_HOUR: begin
				mul_in = {1'b0, num_q[esc_pkg::EPOCH_W-1:3]};
				recip  = esc_pkg::RECIP_3;
			end
			esc_pkg::PH_DAY: begin
				mul_in = num_q[esc_pkg::MUL_W-1:0];
				recip  = esc_pkg::RECIP_7;
			end
			default: begin
				mul_in = num_q[esc_pkg::EPOCH_W-1:2];
				recip  = esc_pkg::RECIP_15;
			end
		endcase
	end

	// quotient from the registered product
	always_comb begin
		case (cmd.phase)
			esc_pkg::PH_SEC, esc_pkg::PH_MIN: prod_sh = prod_q >> esc_pkg::RECIP_15_SH;
			esc_pkg::PH_HOUR:                 prod_sh = prod_q >> esc_pkg::RECIP_3_SH;
			esc_pkg::PH_DAY:                  prod_sh = prod_q >> esc_pkg::RECIP_7_SH;
			default:                          prod_sh = prod_q >> esc_pkg::RECIP_15_SH;
		endcase
	end
	assign quo = prod_sh[esc_pkg::EPOCH_W-1:0];

	// quotient times divisor by shift and add, remainder by subtraction
	always_comb begin
		case (cmd.phase)
			esc_pkg::PH_SEC, esc_pkg::PH_MIN: back = (quo << 6) - (quo << 2);
			esc_pkg::PH_HOUR:                 back = (quo << 4) + (quo << 3);
			esc_pkg::PH_DAY:                  back = (quo << 3) - quo;
			default:                          back = (quo << 6) - (quo << 2);
		endcase
	end
	assign rem = num_q - back;

	// gregorian leap rule from year mod 4, year mod 100 and century mod 4
	assign leap = (year_q[1:0] == 2'b00) && ((year_c_q != 7'd0) || (century_q == 2'd0));
	assign len  = esc_pkg::month_len(mon_q, leap);
	assign fits = (days_q >= {{(esc_pkg::DAYS_W-5){1'b0}}, len});
	assign status.walk_done = !fits;

	// dividend register: epoch seconds, then each quotient in turn
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= epoch_seconds;
		end else if (cmd.fix) begin
			num_q <= quo;
		end
	end

	// 29 x 30 bit product
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= {{(esc_pkg::PROD_W-esc_pkg::MUL_W){1'b0}}, mul_in} *
				{{(esc_pkg::PROD_W-esc_pkg::RECIP_W){1'b0}}, recip};
		end
	end

	// capture each remainder at the end of its phase
	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			case (cmd.phase)
				esc_pkg::PH_SEC:  sec_q  <= rem[5:0];
				esc_pkg::PH_MIN:  min_q  <= rem[5:0];
				esc_pkg::PH_HOUR: hour_q <= rem[4:0];
				esc_pkg::PH_DAY:  wd_q   <= rem[2:0];
				default:          sec_q  <= rem[5:0];
			endcase
		end
	end

	// month walk from january 1970
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q    <= esc_pkg::EPOCH_YEAR;
			year_c_q  <= esc_pkg::EPOCH_YEAR_C;
			century_q <= esc_pkg::EPOCH_CENTURY_4;
			mon_q     <= esc_pkg::MONTH_JAN;
		end else if (cmd.fix && cmd.phase == esc_pkg::PH_DAY) begin
			days_q <= num_q[esc_pkg::DAYS_W-1:0];
		end else if (cmd.walk_step && fits) begin
			days_q <= days_q - {{(esc_pkg::DAYS_W-5){1'b0}}, len};
			if (mon_q == esc_pkg::MONTH_DEC) begin
				mon_q  <= esc_pkg::MONTH_JAN;
				year_q <= year_q + 1'b1;
				if (year_c_q == esc_pkg::LAST_YEAR_C) begin
					year_c_q  <= 7'd0;
					century_q <= century_q + 1'b1;
				end else begin
					year_c_q <= year_c_q + 1'b1;
				end
			end else begin
				mon_q <= mon_q + 1'b1;
			end
		end
	end

	// result ports
	assign second       = sec_q;
	assign minute       = min_q;
	assign hour         = hour_q;
	assign weekday      = wd_q;
	assign year         = year_q;
	assign month        = mon_q + 4'd1;
	assign day_of_month = days_q[4:0] + 5'd1;

endmodule

// ===== dv/epoch_seconds_to_calendar_checker.sv =====
// result checker of the epoch-to-calendar converter: predicts each date and compares it
module epoch_seconds_to_calendar_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [esc_pkg::EPOCH_W-1:0] epoch_seconds,
	input  logic                        done,
	input  logic [5:0]                  second,
	input  logic [5:0]                  minute,
	input  logic [4:0]                  hour,
	input  logic [2:0]                  weekday,
	input  logic [esc_pkg::YEAR_W-1:0]  year,
	input  logic [3:0]                  month,
	input  logic [4:0]                  day_of_month,
	output int unsigned                 fail_count,
	output int unsigned                 pending,
	output int unsigned                 checked,
	output int unsigned                 leap_days
);

	localparam int unsigned EPOCH_W     = esc_pkg::EPOCH_W;
	localparam int unsigned YEAR_W      = esc_pkg::YEAR_W;
	localparam int unsigned FIRST_YEAR  = 1970;
	localparam int unsigned MONTH_FEB_I = 1;
	localparam int unsigned MONTH_DEC_I = 11;
	localparam int unsigned REPORT_MAX  = 10;

	typedef struct packed {
		logic [5:0]        second;
		logic [5:0]        minute;
		logic [4:0]        hour;
		logic [2:0]        weekday;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day_of_month;
	} calendar_t;

	// dates still owed by the converter, oldest first
	calendar_t dates_due[$];

	// gregorian leap rule
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// month index counts from zero at january
	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			MONTH_FEB_I: return leap_year(y) ? 29 : 28;
			3, 5, 8, 10: return 30;
			default:     return 31;
		endcase
	endfunction

	// split off time of day, then walk whole days month by month from 1970
	function automatic calendar_t calendar_of(input logic [EPOCH_W-1:0] secs);
		calendar_t   d;
		int unsigned t;
		int unsigned days;
		int unsigned y;
		int unsigned m;
		int unsigned len;
		t = {1'b0, secs};
		d.second = 6'(t % 60);
		t = t / 60;
		d.minute = 6'(t % 60);
		t = t / 60;
		d.hour = 5'(t % 24);
		days = t / 24;
		d.weekday = 3'(days % 7);
		y = FIRST_YEAR;
		m = 0;
		len = days_in_month(y, m);
		while (days >= len) begin
			days -= len;
			if (m == MONTH_DEC_I) begin
				m = 0;
				y++;
			end else begin
				m++;
			end
			len = days_in_month(y, m);
		end
		d.year = YEAR_W'(y);
		d.month = 4'(m + 1);
		d.day_of_month = 5'(days + 1);
		return d;
	endfunction

	// compare each result word with the oldest prediction, then log new words
	always @(posedge clk or negedge arst_n) begin
		calendar_t want;
		calendar_t got;
		bit        bad;
		if (!arst_n) begin
			dates_due.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			leap_days  <= 0;
		end else begin
			if (done) begin
				got = '{second, minute, hour, weekday, year, month, day_of_month};
				if (dates_due.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: result word with nothing outstanding: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
							$time, got.year, got.month, got.day_of_month,
							got.hour, got.minute, got.second, got.weekday);
					fail_count <= fail_count + 1;
				end else begin
					want = dates_due.pop_front();
					bad = (got.second !== want.second) || (got.minute !== want.minute) ||
						(got.hour !== want.hour) || (got.weekday !== want.weekday) ||
						(got.year !== want.year) || (got.month !== want.month) ||
						(got.day_of_month !== want.day_of_month);
					if (bad) begin
						if (fail_count < REPORT_MAX)
							$display("%0t: want %0d-%0d-%0d %0d:%0d:%0d wd %0d, got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
								$time, want.year, want.month, want.day_of_month,
								want.hour, want.minute, want.second, want.weekday,
								got.year, got.month, got.day_of_month,
								got.hour, got.minute, got.second, got.weekday);
						fail_count <= fail_count + 1;
					end else if (want.month == 4'd2 && want.day_of_month == 5'd29) begin
						leap_days <= leap_days + 1;
					end
					checked <= checked + 1;
				end
			end
			if (start && !busy)
				dates_due.push_back(calendar_of(epoch_seconds));
			pending <= $unsigned(dates_due.size());
		end
	end

endmodule

// ===== dv/epoch_seconds_to_calendar_tb.sv =====
// stimulus and verdict for the epoch-to-calendar converter
module epoch_seconds_to_calendar_tb;

	localparam int unsigned EPOCH_W        = esc_pkg::EPOCH_W;
	localparam int unsigned YEAR_W         = esc_pkg::YEAR_W;
	localparam int unsigned RANDOM_WORDS   = 640;
	localparam int unsigned LAST_SECOND    = 32'h7fff_ffff;
	localparam int unsigned SECS_PER_DAY   = 86400;
	localparam int unsigned LAST_WHOLE_DAY = 24854;
	localparam int unsigned SETTLE_CYCLES  = 1000;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              start         = 1'b0;
	logic [EPOCH_W-1:0] epoch_seconds = '0;
	logic              busy;
	logic              done;
	logic [5:0]        second;
	logic [5:0]        minute;
	logic [4:0]        hour;
	logic [2:0]        weekday;
	logic [YEAR_W-1:0] year;
	logic [3:0]        month;
	logic [4:0]        day_of_month;
	int unsigned       fail_count;
	int unsigned       pending;
	int unsigned       checked;
	int unsigned       leap_days;
	int unsigned       words_sent = 0;

	always #5 clk = ~clk;

	epoch_seconds_to_calendar dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.epoch_seconds (epoch_seconds),
		.busy          (busy),
		.done          (done),
		.second        (second),
		.minute        (minute),
		.hour          (hour),
		.weekday       (weekday),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month)
	);

	epoch_seconds_to_calendar_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.epoch_seconds (epoch_seconds),
		.done          (done),
		.second        (second),
		.minute        (minute),
		.hour          (hour),
		.weekday       (weekday),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.leap_days     (leap_days)
	);

	// mostly back-to-back or short waits, now and then long enough to let the block go idle
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 300);
		return $urandom_range(900, 1200);
	endfunction

	// whole range, day boundaries, early years and the last years of the range
	function automatic logic [EPOCH_W-1:0] pick_seconds();
		int unsigned r;
		int unsigned day;
		r = $urandom_range(99);
		day = $urandom_range(LAST_WHOLE_DAY);
		if (r < 50) return EPOCH_W'($urandom);
		if (r < 65) return EPOCH_W'(day * SECS_PER_DAY);
		if (r < 80) return EPOCH_W'(day * SECS_PER_DAY + SECS_PER_DAY - 1);
		if (r < 90) return EPOCH_W'($urandom_range(100_000_000));
		return EPOCH_W'(LAST_SECOND - $urandom_range(100_000_000));
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(input logic [EPOCH_W-1:0] secs, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	// stop offering and wait until every converted date is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [EPOCH_W-1:0] corner_words[$] = '{
			31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
			31'd31535999, 31'd31536000,   // end of 1970, start of 1971
			31'd68169600, 31'd68256000,   // 1972 leap day, then march 1st
			31'd36633600,                 // march 1st of a common year
			31'd94608000, 31'd94694400,   // last day of a leap year, new year after it
			31'd946684799, 31'd951782400, // eve of 2000, leap day of a century leap year
			31'd951868800, 31'd99792000,  // march 2000, then march of a common year
			31'h2aaa_aaaa, 31'h5555_5555,
			31'h7fff_ffff, 31'h7fff_fffe
		};
		int unsigned burst_left;
		int unsigned gap;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, with random gaps
		foreach (corner_words[i])
			send_word(corner_words[i], pick_gap());
		drain();

		// random words; stretches with no gaps and the odd full drain
		burst_left = 0;
		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			if (burst_left == 0 && $urandom_range(39) == 0)
				burst_left = $urandom_range(10, 30);
			if (burst_left != 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = pick_gap();
			end
			if ($urandom_range(49) == 0)
				drain();
			send_word(pick_seconds(), gap);
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d words sent, %0d dates compared, %0d of them february 29th",
			words_sent, checked, leap_days);
		// a date still owed at the end counts as a failure too
		if (fail_count == 0 && pending == 0)
			$display("epoch_seconds_to_calendar: match");
		else
			$display("epoch_seconds_to_calendar: mismatch");
		$finish;
	end

	// hang guard
	initial begin
		#60_000_000;
		$display("epoch_seconds_to_calendar: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_ctrl.sv
hdl/esc_dpath.sv
hdl/epoch_seconds_to_calendar.sv
dv/epoch_seconds_to_calendar_checker.sv
dv/epoch_seconds_to_calendar_tb.sv
